// ===== rtl/core/ipc_rdv_pkg.sv =====
`timescale 1ns / 1ps

package ipc_rdv_pkg;

    // Task table geometry
    localparam int TASK_COUNT = 16;
    localparam int ID_W       = 4;
    localparam int PEER_W     = 5;
    localparam int MSG_W      = 64;
    localparam int P_PAYLOAD_BITS = 64;

    // Peer and link codes
    localparam logic [PEER_W-1:0] PEER_ANY   = PEER_W'(TASK_COUNT);
    localparam logic [PEER_W-1:0] PEER_NONE  = PEER_W'(TASK_COUNT + 1);
    localparam logic [PEER_W-1:0] LINK_EMPTY = PEER_W'(TASK_COUNT);

    // Request operations
    localparam logic [1:0] CMD_SEND  = 2'd0;
    localparam logic [1:0] CMD_CALL  = 2'd1;
    localparam logic [1:0] CMD_RECV  = 2'd2;
    localparam logic [1:0] CMD_REPLY = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_DELIVER = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_BLOCK   = 2'd2;
    localparam logic [1:0] KIND_REJECT  = 2'd3;

    // Per-task run state
    localparam logic [1:0] TS_READY   = 2'd0;
    localparam logic [1:0] TS_SENDBLK = 2'd1;
    localparam logic [1:0] TS_RECVBLK = 2'd2;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_REJECT,
        OP_DELIVER,
        OP_RECVWAIT,
        OP_PARK,
        OP_SETHEAD,
        OP_SETTAIL,
        OP_STEP,
        OP_RHEAD,
        OP_UNLINK,
        OP_RDELIV,
        OP_RRELEASE
    } dp_op_t;

    // Table read address source
    typedef enum logic [1:0] {
        ADDR_ME,
        ADDR_PEER,
        ADDR_PTR
    } addr_sel_t;

    typedef struct packed {
        dp_op_t    op;
        addr_sel_t addr_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       rd_ready;
        logic       bad_peer;
        logic       take_ok;
        logic       reply_ok;
        logic       ptr_empty;
        logic       ptr_match;
        logic       link_empty;
        logic       out_free;
    } dp_status_t;

endpackage

// ===== rtl/core/sync_ipc_rendezvous_engine_top.sv =====
`timescale 1ns / 1ps
// Rendezvous engine for send / call / receive / reply among 16 tasks.
// Input channel (in_valid / in_ready): one request per handshake carrying
// cmd, caller_task, peer_task and payload. Output channel (out_valid /
// out_ready): one result per handshake, kind, target_task, source_task,
// message and last; a request yields one or two results, last marks the end.
// The first result is registered after acceptance: in the check step for a
// rejected caller or peer, and in the peer step for a direct delivery or a
// rejected reply; a receive that blocks on an empty queue issues it from the
// walk step. Parking a sender walks the receiver's sender list one entry per
// cycle, and a receive searches its list the same way, so their first result
// follows the walk. One request is in flight at a time, and the next one is
// accepted once the controller is back in idle after the final result.
// The output register lets the next request be accepted while the final
// result of the previous one still waits for out_ready. While the receiver
// stalls, the engine holds at the step that would produce the next result.
// Reset sets every task ready, with no awaited peer and empty sender queues;
// staged messages are not cleared and are read only once written.
module sync_ipc_rendezvous_engine_top #(
    parameter int PAYLOAD_BITS = ipc_rdv_pkg::P_PAYLOAD_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     cmd,
    input  logic [ipc_rdv_pkg::ID_W-1:0]   caller_task,
    input  logic [ipc_rdv_pkg::PEER_W-1:0] peer_task,
    input  logic [ipc_rdv_pkg::MSG_W-1:0]  payload,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     kind,
    output logic [ipc_rdv_pkg::ID_W-1:0]   target_task,
    output logic [ipc_rdv_pkg::ID_W-1:0]   source_task,
    output logic [ipc_rdv_pkg::MSG_W-1:0]  message,
    output logic                           last
);

    import ipc_rdv_pkg::*;

    ctrl_cmd_t  ctrl;
    dp_status_t status;

    ipc_rdv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .ctrl     (ctrl)
    );

    ipc_rdv_dp #(
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .status      (status),
        .cmd         (cmd),
        .caller_task (caller_task),
        .peer_task   (peer_task),
        .payload     (payload),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .target_task (target_task),
        .source_task (source_task),
        .message     (message),
        .last        (last)
    );

endmodule

// ===== rtl/core/ipc_rdv_ram.sv =====
`timescale 1ns / 1ps

module ipc_rdv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ipc_rdv_dp.sv =====
`timescale 1ns / 1ps

module ipc_rdv_dp #(
    parameter int PAYLOAD_BITS = ipc_rdv_pkg::P_PAYLOAD_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ipc_rdv_pkg::ctrl_cmd_t         ctrl,
    output ipc_rdv_pkg::dp_status_t        status,
    input  logic [1:0]                     cmd,
    input  logic [ipc_rdv_pkg::ID_W-1:0]   caller_task,
    input  logic [ipc_rdv_pkg::PEER_W-1:0] peer_task,
    input  logic [ipc_rdv_pkg::MSG_W-1:0]  payload,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     kind,
    output logic [ipc_rdv_pkg::ID_W-1:0]   target_task,
    output logic [ipc_rdv_pkg::ID_W-1:0]   source_task,
    output logic [ipc_rdv_pkg::MSG_W-1:0]  message,
    output logic                           last
);

    import ipc_rdv_pkg::*;

    // Task tables
    logic [1:0]        st_reg   [TASK_COUNT];
    logic [1:0]        st_next  [TASK_COUNT];
    logic [PEER_W-1:0] aw_reg   [TASK_COUNT];
    logic [PEER_W-1:0] aw_next  [TASK_COUNT];
    logic              pc_reg   [TASK_COUNT];
    logic              pc_next  [TASK_COUNT];
    logic [PEER_W-1:0] head_reg [TASK_COUNT];
    logic [PEER_W-1:0] head_next[TASK_COUNT];
    logic [PEER_W-1:0] link_reg [TASK_COUNT];
    logic [PEER_W-1:0] link_next[TASK_COUNT];

    // Request and walk registers
    logic [1:0]              cmd_reg;
    logic [ID_W-1:0]         me_reg;
    logic [PEER_W-1:0]       peer_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [PEER_W-1:0]       ptr_reg,  ptr_next;
    logic [PEER_W-1:0]       prev_reg, prev_next;
    logic [ID_W-1:0]         src_reg,  src_next;
    logic                    spc_reg,  spc_next;

    // Result register
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       kind_reg,   kind_next;
    logic [ID_W-1:0]  target_reg, target_next;
    logic [ID_W-1:0]  source_reg, source_next;
    logic [MSG_W-1:0] msg_reg,    msg_next;
    logic             last_reg,   last_next;

    // Message store
    logic                    ram_we;
    logic [ID_W-1:0]         ram_waddr;
    logic [PAYLOAD_BITS-1:0] ram_wdata;
    logic                    ram_re;
    logic [PAYLOAD_BITS-1:0] ram_rdata;

    logic [ID_W-1:0]   addr;
    logic [1:0]        rd_st;
    logic [PEER_W-1:0] rd_aw;
    logic              rd_pc;
    logic [PEER_W-1:0] rd_head;
    logic [PEER_W-1:0] rd_link;
    logic [PEER_W-1:0] me_ext;
    logic              out_free;

    ipc_rdv_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (TASK_COUNT)
    ) u_msg_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ptr_reg[ID_W-1:0]),
        .rdata (ram_rdata)
    );

    // Select the table read address
    always_comb
    begin
        unique case (ctrl.addr_sel)
            ADDR_ME:   addr = me_reg;
            ADDR_PEER: addr = peer_reg[ID_W-1:0];
            ADDR_PTR:  addr = ptr_reg[ID_W-1:0];
            default:   addr = me_reg;
        endcase
    end

    assign rd_st    = st_reg[addr];
    assign rd_aw    = aw_reg[addr];
    assign rd_pc    = pc_reg[addr];
    assign rd_head  = head_reg[addr];
    assign rd_link  = link_reg[addr];
    assign me_ext   = {1'b0, me_reg};
    assign out_free = !out_valid_reg || out_ready;

    // Report status to the controller
    always_comb
    begin
        status.cmd        = cmd_reg;
        status.rd_ready   = (rd_st == TS_READY);
        status.bad_peer   = (cmd_reg == CMD_RECV) ? (peer_reg > PEER_ANY)
                                                  : (peer_reg >= PEER_W'(TASK_COUNT));
        status.take_ok    = (rd_st == TS_RECVBLK) && (rd_aw == PEER_ANY || rd_aw == me_ext);
        status.reply_ok   = (rd_st == TS_RECVBLK) && (rd_aw == me_ext);
        status.ptr_empty  = ptr_reg[ID_W];
        status.ptr_match  = (peer_reg == PEER_ANY) || (ptr_reg == peer_reg);
        status.link_empty = rd_link[ID_W];
        status.out_free   = out_free;
    end

    // Apply the current operation
    always_comb
    begin
        st_next   = st_reg;
        aw_next   = aw_reg;
        pc_next   = pc_reg;
        head_next = head_reg;
        link_next = link_reg;
        ptr_next  = ptr_reg;
        prev_next = prev_reg;
        src_next  = src_reg;
        spc_next  = spc_reg;
        ram_we    = 1'b0;
        ram_waddr = me_reg;
        ram_wdata = pay_reg;
        ram_re    = 1'b0;

        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        target_next    = target_reg;
        source_next    = source_reg;
        msg_next       = msg_reg;
        last_next      = last_reg;

        unique case (ctrl.op)
            OP_NONE, OP_LOAD:
            begin
            end
            OP_REJECT:
            begin
                out_valid_next = 1'b1;
                kind_next      = KIND_REJECT;
                target_next    = me_reg;
                source_next    = '0;
                msg_next       = '0;
                last_next      = 1'b1;
            end
            OP_DELIVER:
            begin
                st_next[peer_reg[ID_W-1:0]] = TS_READY;
                aw_next[peer_reg[ID_W-1:0]] = PEER_NONE;
                ram_we         = 1'b1;
                ram_waddr      = peer_reg[ID_W-1:0];
                out_valid_next = 1'b1;
                kind_next      = KIND_DELIVER;
                target_next    = peer_reg[ID_W-1:0];
                source_next    = me_reg;
                msg_next       = MSG_W'(pay_reg);
                last_next      = (cmd_reg != CMD_CALL);
            end
            OP_RECVWAIT:
            begin
                st_next[me_reg] = TS_RECVBLK;
                aw_next[me_reg] = peer_reg;
                out_valid_next  = 1'b1;
                kind_next       = KIND_BLOCK;
                target_next     = me_reg;
                source_next     = '0;
                msg_next        = '0;
                last_next       = 1'b1;
            end
            OP_PARK:
            begin
                ram_we            = 1'b1;
                pc_next[me_reg]   = (cmd_reg == CMD_CALL);
                st_next[me_reg]   = TS_SENDBLK;
                link_next[me_reg] = LINK_EMPTY;
                ptr_next          = rd_head;
            end
            OP_SETHEAD, OP_SETTAIL:
            begin
                if (ctrl.op == OP_SETHEAD)
                begin
                    head_next[peer_reg[ID_W-1:0]] = me_ext;
                end
                else
                begin
                    link_next[ptr_reg[ID_W-1:0]] = me_ext;
                end
                out_valid_next = 1'b1;
                kind_next      = KIND_BLOCK;
                target_next    = me_reg;
                source_next    = '0;
                msg_next       = '0;
                last_next      = 1'b1;
            end
            OP_STEP:
            begin
                prev_next = ptr_reg;
                ptr_next  = rd_link;
            end
            OP_RHEAD:
            begin
                ptr_next  = rd_head;
                prev_next = LINK_EMPTY;
            end
            OP_UNLINK:
            begin
                if (prev_reg[ID_W])
                begin
                    head_next[me_reg] = rd_link;
                end
                else
                begin
                    link_next[prev_reg[ID_W-1:0]] = rd_link;
                end
                link_next[ptr_reg[ID_W-1:0]] = LINK_EMPTY;
                if (rd_pc)
                begin
                    aw_next[ptr_reg[ID_W-1:0]] = me_ext;
                    st_next[ptr_reg[ID_W-1:0]] = TS_RECVBLK;
                end
                else
                begin
                    st_next[ptr_reg[ID_W-1:0]] = TS_READY;
                end
                ram_re   = 1'b1;
                src_next = ptr_reg[ID_W-1:0];
                spc_next = rd_pc;
            end
            OP_RDELIV:
            begin
                out_valid_next = 1'b1;
                kind_next      = KIND_DELIVER;
                target_next    = me_reg;
                source_next    = src_reg;
                msg_next       = MSG_W'(ram_rdata);
                last_next      = 1'b0;
            end
            OP_RRELEASE:
            begin
                out_valid_next = 1'b1;
                kind_next      = spc_reg ? KIND_BLOCK : KIND_RELEASE;
                target_next    = src_reg;
                source_next    = '0;
                msg_next       = '0;
                last_next      = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Hold tables and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TASK_COUNT; i++)
            begin
                st_reg[i]   <= TS_READY;
                aw_reg[i]   <= PEER_NONE;
                pc_reg[i]   <= 1'b0;
                head_reg[i] <= LINK_EMPTY;
                link_reg[i] <= LINK_EMPTY;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            aw_reg        <= aw_next;
            pc_reg        <= pc_next;
            head_reg      <= head_next;
            link_reg      <= link_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold request, walk and result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.op == OP_LOAD)
        begin
            cmd_reg  <= cmd;
            me_reg   <= caller_task;
            peer_reg <= peer_task;
            pay_reg  <= payload[PAYLOAD_BITS-1:0];
        end
        ptr_reg    <= ptr_next;
        prev_reg   <= prev_next;
        src_reg    <= src_next;
        spc_reg    <= spc_next;
        kind_reg   <= kind_next;
        target_reg <= target_next;
        source_reg <= source_next;
        msg_reg    <= msg_next;
        last_reg   <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign target_task = target_reg;
    assign source_task = source_reg;
    assign message     = msg_reg;
    assign last        = last_reg;

endmodule

// ===== rtl/core/ipc_rdv_ctrl.sv =====
`timescale 1ns / 1ps

module ipc_rdv_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  ipc_rdv_pkg::dp_status_t status,
    output ipc_rdv_pkg::ctrl_cmd_t  ctrl
);

    import ipc_rdv_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_PEER,
        S_CALLW,
        S_PUSH,
        S_TAIL,
        S_RWALK,
        S_RDATA,
        S_RSECOND
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;

    // Sequence one request at a time
    always_comb
    begin
        state_next    = state_reg;
        ctrl.op       = OP_NONE;
        ctrl.addr_sel = ADDR_ME;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    ctrl.op    = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ctrl.addr_sel = ADDR_ME;
                if (!status.rd_ready || status.bad_peer)
                begin
                    if (status.out_free)
                    begin
                        ctrl.op    = OP_REJECT;
                        state_next = S_IDLE;
                    end
                end
                else if (status.cmd == CMD_RECV)
                begin
                    ctrl.op    = OP_RHEAD;
                    state_next = S_RWALK;
                end
                else
                begin
                    state_next = S_PEER;
                end
            end
            S_PEER:
            begin
                ctrl.addr_sel = ADDR_PEER;
                if (status.cmd == CMD_REPLY)
                begin
                    if (status.out_free)
                    begin
                        ctrl.op    = status.reply_ok ? OP_DELIVER : OP_REJECT;
                        state_next = S_IDLE;
                    end
                end
                else if (status.take_ok)
                begin
                    if (status.out_free)
                    begin
                        ctrl.op    = OP_DELIVER;
                        state_next = (status.cmd == CMD_CALL) ? S_CALLW : S_IDLE;
                    end
                end
                else
                begin
                    ctrl.op    = OP_PARK;
                    state_next = S_PUSH;
                end
            end
            S_CALLW:
            begin
                if (status.out_free)
                begin
                    ctrl.op    = OP_RECVWAIT;
                    state_next = S_IDLE;
                end
            end
            S_PUSH:
            begin
                if (!status.ptr_empty)
                begin
                    state_next = S_TAIL;
                end
                else if (status.out_free)
                begin
                    ctrl.op    = OP_SETHEAD;
                    state_next = S_IDLE;
                end
            end
            S_TAIL:
            begin
                ctrl.addr_sel = ADDR_PTR;
                if (!status.link_empty)
                begin
                    ctrl.op = OP_STEP;
                end
                else if (status.out_free)
                begin
                    ctrl.op    = OP_SETTAIL;
                    state_next = S_IDLE;
                end
            end
            S_RWALK:
            begin
                ctrl.addr_sel = ADDR_PTR;
                if (status.ptr_empty)
                begin
                    if (status.out_free)
                    begin
                        ctrl.op    = OP_RECVWAIT;
                        state_next = S_IDLE;
                    end
                end
                else if (status.ptr_match)
                begin
                    ctrl.op    = OP_UNLINK;
                    state_next = S_RDATA;
                end
                else
                begin
                    ctrl.op = OP_STEP;
                end
            end
            S_RDATA:
            begin
                if (status.out_free)
                begin
                    ctrl.op    = OP_RDELIV;
                    state_next = S_RSECOND;
                end
            end
            S_RSECOND:
            begin
                if (status.out_free)
                begin
                    ctrl.op    = OP_RRELEASE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        in_ready_next = (state_next == S_IDLE);
    end

    // Hold state and the registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready = in_ready_reg && (state_reg == S_IDLE);

endmodule

// ===== rtl/core/ipc_rdv_checker.sv =====
`timescale 1ns / 1ps

module ipc_rdv_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [1:0]                     kind,
    input logic [ipc_rdv_pkg::ID_W-1:0]   source_task,
    input logic [ipc_rdv_pkg::MSG_W-1:0]  message,
    input logic                           last
);

    import ipc_rdv_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(message)
            && $stable(last))
        else $error("stalled result changed");

    // Non-delivery results carry no sender and no body
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_DELIVER |-> source_task == '0 && message == '0)
        else $error("non-delivery result carries data");

    // Rejection and release always end the request
    a_end_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_REJECT || kind == KIND_RELEASE) |-> last)
        else $error("reject or release not final");

    // A non-final result is always a delivery
    a_first_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> kind == KIND_DELIVER)
        else $error("non-final result is not a delivery");

endmodule

bind sync_ipc_rendezvous_engine_top ipc_rdv_checker u_ipc_rdv_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .source_task (source_task),
    .message     (message),
    .last        (last)
);
